/* sv/bphd_pkg.sv */
package bphd_pkg;

  // Integrator width and the field widths
  localparam int INTEG_WIDTH = 20;
  localparam int TEMP_W      = 12;
  localparam int HUM_W       = 10;
  localparam int SP_W        = 10;
  localparam int BAND_W      = 6;
  localparam int DUTY_W      = 7;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 10;

  // Working width for the band compares and the error
  localparam int CMP_W = 14;
  // The error inside the band is below 64 in magnitude
  localparam int ERR_W = 8;
  // PI numerator: integrator plus 100*err plus the rounding offset
  localparam int NUM_W = ((INTEG_WIDTH > CMP_W) ? INTEG_WIDTH : CMP_W) + 2;

  // Plausibility limits, tenths
  localparam int TEMP_MAX = 990;
  localparam int TEMP_MIN = -100;
  localparam int HUM_MAX  = 990;

  // Duty levels
  localparam logic [DUTY_W-1:0] DUTY_OFF    = 7'd0;
  localparam logic [DUTY_W-1:0] DUTY_FULL   = 7'd99;
  localparam logic [DUTY_W-1:0] DUTY_ABSENT = 7'd50;

  // Divide by ten through a reciprocal: floor(n/10) = (n*205) >> 11 for n < 1029
  localparam int RECIP_10   = 205;
  localparam int RECIP_SH   = 11;
  localparam int QNUM_W     = 10;
  localparam int NUM_CLAMP  = 1000;
  localparam int P_GAIN     = 100;
  localparam int ROUND_OFFS = 500;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_REGULATE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OFF      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND     = 8'd1;

  localparam logic [BAND_W-1:0] BAND_RESET = 6'd5;

  typedef struct packed {
    logic                     sensor_ok;
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic [HUM_W-1:0]         humidity_tenths;
  } bphd_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty_percent;
    logic [STATUS_W-1:0] status;
  } bphd_out_t;

  typedef struct packed {
    logic [SP_W-1:0]   setpoint_tenths;
    logic [BAND_W-1:0] band_tenths;
  } bphd_cfg_t;

  typedef struct packed {
    logic                          drop;
    logic                          integ_we;
    logic signed [INTEG_WIDTH-1:0] integ_nxt;
    bphd_out_t                     res;
  } bphd_calc_t;

endpackage

/* sv/band_pi_heater_duty_unit.sv */
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | in_data   (bphd_in_t)
// out_    | output    | out_valid / out_ready| out_data  (bphd_out_t)
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One reading a cycle unless a stalled result holds the input register.
// The input register feeds the PI logic, the result register holds the duty.
// The integrator is updated as a present, plausible reading leaves the input register.
// A stalled result holds the input register; a dropped reading never waits.
// Synchronous active-low reset clears valids, integrator and setpoint and sets the band to 5.
module band_pi_heater_duty_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bphd_pkg::bphd_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bphd_pkg::bphd_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bphd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bphd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bphd_pkg::*;

  bphd_cfg_t                     cfg_q;
  bphd_calc_t                    calc;
  bphd_in_t                      s1_data_r;
  logic                          s1_vld_r;
  logic                          s1_vld_nxt;
  bphd_out_t                     out_data_r;
  logic                          out_vld_r;
  logic                          out_vld_nxt;
  logic signed [INTEG_WIDTH-1:0] integ_r;
  logic                          s1_go;
  logic                          in_take;
  logic                          res_load;

  bphd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_q     (cfg_q)
  );

  bphd_calc u_calc (
    .item  (s1_data_r),
    .cfg   (cfg_q),
    .integ (integ_r),
    .calc  (calc)
  );

  // Advance the input register when the result slot frees or the reading drops
  assign s1_go    = s1_vld_r && (calc.drop || !out_vld_r || out_ready);
  assign res_load = s1_go && !calc.drop;
  assign in_ready = !s1_vld_r || s1_go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      integ_r   <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_go && calc.integ_we) begin
        integ_r <= calc.integ_nxt;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (res_load) begin
      out_data_r <= calc.res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_clear_on_force: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !calc.drop && (calc.res.status == ST_OFF || calc.res.status == ST_FULL))
    |=> (integ_r == '0))
    else $error("integrator not cleared after forced duty");

  a_absent_keeps_integ: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_data_r.sensor_ok) |=> $stable(integ_r))
    else $error("integrator changed on absent sensor");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.duty_percent <= DUTY_FULL))
    else $error("duty above limit");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_ready)
    else $error("input stalled with empty stage");
`endif

endmodule

/* sv/bphd_cfg_regs.sv */
module bphd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bphd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bphd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bphd_pkg::bphd_cfg_t             cfg_q
);
  import bphd_pkg::*;

  logic [SP_W-1:0]   setpoint_r;
  logic [BAND_W-1:0] band_r;

  // Always ready; writes are registered
  assign cfg_ready = 1'b1;

  // Decode the index and hold the registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      band_r     <= BAND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT: setpoint_r <= cfg_wdata[SP_W-1:0];
        REG_BAND:     band_r     <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_q.setpoint_tenths = setpoint_r;
  assign cfg_q.band_tenths     = band_r;

endmodule

/* sv/bphd_calc.sv */
module bphd_calc (
  input  bphd_pkg::bphd_in_t                   item,
  input  bphd_pkg::bphd_cfg_t                  cfg,
  input  logic signed [bphd_pkg::INTEG_WIDTH-1:0] integ,
  output bphd_pkg::bphd_calc_t                 calc
);
  import bphd_pkg::*;

  localparam logic signed [INTEG_WIDTH:0] ACC_MAX = (INTEG_WIDTH+1)'((64'sd1 <<< (INTEG_WIDTH-1)) - 1);
  localparam logic signed [INTEG_WIDTH:0] ACC_MIN = (INTEG_WIDTH+1)'(-(64'sd1 <<< (INTEG_WIDTH-1)));

  logic signed [CMP_W-1:0]       temp_s;
  logic signed [CMP_W-1:0]       sp_s;
  logic signed [CMP_W-1:0]       band_s;
  logic signed [CMP_W-1:0]       err_full;
  logic signed [ERR_W-1:0]       err;
  logic signed [INTEG_WIDTH:0]   acc_wide;
  logic signed [INTEG_WIDTH-1:0] acc;
  logic signed [NUM_W-1:0]       num;
  logic [QNUM_W+DUTY_W+1-1:0]    prod;
  logic [DUTY_W-1:0]             duty_pi;
  logic                          implausible;
  logic                          forced_off;
  logic                          forced_full;

  // Widen the operands to a common signed width
  assign temp_s   = CMP_W'(item.temperature_tenths);
  assign sp_s     = signed'({{(CMP_W-SP_W){1'b0}}, cfg.setpoint_tenths});
  assign band_s   = signed'({{(CMP_W-BAND_W){1'b0}}, cfg.band_tenths});
  assign err_full = sp_s - temp_s;
  assign err      = err_full[ERR_W-1:0];

  // Plausibility and band decisions
  assign implausible = (temp_s > CMP_W'(TEMP_MAX)) || (temp_s < CMP_W'(TEMP_MIN)) ||
                       (item.humidity_tenths > HUM_W'(HUM_MAX));
  assign forced_off  = (sp_s <= temp_s - band_s);
  assign forced_full = (sp_s >= temp_s + band_s);

  // Saturating integrator sum
  always_comb begin
    acc_wide = (INTEG_WIDTH+1)'(integ) + (INTEG_WIDTH+1)'(err);
    if (acc_wide > ACC_MAX) begin
      acc = ACC_MAX[INTEG_WIDTH-1:0];
    end else if (acc_wide < ACC_MIN) begin
      acc = ACC_MIN[INTEG_WIDTH-1:0];
    end else begin
      acc = acc_wide[INTEG_WIDTH-1:0];
    end
  end

  // PI numerator, then clamp and divide by ten
  assign num  = NUM_W'(err) * NUM_W'(P_GAIN) + NUM_W'(ROUND_OFFS) + NUM_W'(acc);
  assign prod = (QNUM_W+DUTY_W+1)'(num[QNUM_W-1:0]) * (QNUM_W+DUTY_W+1)'(RECIP_10);

  always_comb begin
    if (num < 0) begin
      duty_pi = DUTY_OFF;
    end else if (num >= NUM_W'(NUM_CLAMP)) begin
      duty_pi = DUTY_FULL;
    end else begin
      duty_pi = prod[RECIP_SH +: DUTY_W];
    end
  end

  // Pick the result and the integrator update
  always_comb begin
    calc.drop      = 1'b0;
    calc.integ_we  = 1'b0;
    calc.integ_nxt = acc;
    calc.res.duty_percent = duty_pi;
    calc.res.status       = ST_REGULATE;
    if (!item.sensor_ok) begin
      calc.res.duty_percent = DUTY_ABSENT;
      calc.res.status       = ST_ABSENT;
    end else if (implausible) begin
      calc.drop = 1'b1;
    end else if (forced_off) begin
      calc.integ_we  = 1'b1;
      calc.integ_nxt = '0;
      calc.res.duty_percent = DUTY_OFF;
      calc.res.status       = ST_OFF;
    end else if (forced_full) begin
      calc.integ_we  = 1'b1;
      calc.integ_nxt = '0;
      calc.res.duty_percent = DUTY_FULL;
      calc.res.status       = ST_FULL;
    end else begin
      calc.integ_we = 1'b1;
    end
  end

endmodule
